[hdl/iir_df2_pkg.sv]
`default_nettype none

package iir_df2_pkg;

   localparam int MAX_ORDER    = 2;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 32;
   localparam int DELAY_WIDTH  = 48;
   localparam int FRAC_BITS    = 28;
   localparam int ACC_FRAC     = 2 * FRAC_BITS;
   localparam int OUT_SHIFT    = ACC_FRAC - (SAMPLE_WIDTH - 1);
   localparam int CHUNK_WIDTH  = DELAY_WIDTH / 2;
   localparam int PROD_WIDTH   = COEF_WIDTH + CHUNK_WIDTH + 1;
   localparam int ACC_WIDTH    = COEF_WIDTH + DELAY_WIDTH + 4;
   localparam int ORDER_WIDTH  = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int STEP_WIDTH   = 4;

   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_FEED_FWD_0  = 3'd0,
      REG_FEED_FWD_1  = 3'd1,
      REG_FEED_FWD_2  = 3'd2,
      REG_FEED_BACK_1 = 3'd3,
      REG_FEED_BACK_2 = 3'd4,
      REG_NUMER_ORDER = 3'd5,
      REG_DENOM_ORDER = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      CF_A1,
      CF_A2,
      CF_B0,
      CF_B1,
      CF_B2
   } coef_sel_type;

   typedef enum logic [1:0] {
      SRC_W0,
      SRC_W1,
      SRC_W2
   } src_sel_type;

   typedef enum logic [1:0] {
      RND_NONE,
      RND_W,
      RND_Y
   } rnd_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_DEN_LT1,
      COND_DEN_LT2,
      COND_NUM_LT1,
      COND_NUM_LT2
   } cond_type;

   typedef struct packed {
      logic                  mul_en;
      logic                  mul_neg;
      logic                  mul_hi;
      coef_sel_type          coef_sel;
      src_sel_type           src_sel;
      logic                  load_x;
      rnd_type               rnd;
      cond_type              cond;
      logic [STEP_WIDTH-1:0] target;
      logic                  last;
   } uop_type;

   localparam uop_type UOP_NOP = '{
      mul_en:   1'b0,
      mul_neg:  1'b0,
      mul_hi:   1'b0,
      coef_sel: CF_B0,
      src_sel:  SRC_W0,
      load_x:   1'b0,
      rnd:      RND_NONE,
      cond:     COND_NEVER,
      target:   '0,
      last:     1'b0
   };

   typedef struct packed {
      logic    start;
      logic    clear;
      logic    exec;
      uop_type uop;
   } ctl_type;

   typedef struct packed {
      logic den_ge1;
      logic den_ge2;
      logic num_ge1;
      logic num_ge2;
   } ord_type;

   typedef struct packed {
      logic                           cmd;
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] filtered;
      logic                           saturated;
      logic                           last_out;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/iir_df2_seq.sv]
`default_nettype none

module iir_df2_seq import iir_df2_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire logic    req_cmd,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire ord_type ord,
   output ctl_type      ctl
);

   localparam logic [STEP_WIDTH-1:0] STEP_DRAIN_W = 4'd5;
   localparam logic [STEP_WIDTH-1:0] STEP_DRAIN_Y = 4'd13;
   localparam logic [STEP_WIDTH-1:0] STEP_LAST    = 4'd14;

   function automatic uop_type rom_word(input logic [STEP_WIDTH-1:0] addr);
      uop_type u;
      u = UOP_NOP;
      case (addr)
         4'd0: begin
            u.load_x = 1'b1;
            u.cond   = COND_DEN_LT1;
            u.target = STEP_DRAIN_W;
         end
         4'd1: begin
            u.mul_en = 1'b1; u.mul_neg = 1'b1; u.coef_sel = CF_A1; u.src_sel = SRC_W1;
         end
         4'd2: begin
            u.mul_en = 1'b1; u.mul_neg = 1'b1; u.mul_hi = 1'b1;
            u.coef_sel = CF_A1; u.src_sel = SRC_W1;
            u.cond = COND_DEN_LT2; u.target = STEP_DRAIN_W;
         end
         4'd3: begin
            u.mul_en = 1'b1; u.mul_neg = 1'b1; u.coef_sel = CF_A2; u.src_sel = SRC_W2;
         end
         4'd4: begin
            u.mul_en = 1'b1; u.mul_neg = 1'b1; u.mul_hi = 1'b1;
            u.coef_sel = CF_A2; u.src_sel = SRC_W2;
         end
         4'd5: begin
            u = UOP_NOP;
         end
         4'd6: begin
            u.rnd = RND_W;
         end
         4'd7: begin
            u.mul_en = 1'b1; u.coef_sel = CF_B0; u.src_sel = SRC_W0;
         end
         4'd8: begin
            u.mul_en = 1'b1; u.mul_hi = 1'b1; u.coef_sel = CF_B0; u.src_sel = SRC_W0;
            u.cond = COND_NUM_LT1; u.target = STEP_DRAIN_Y;
         end
         4'd9: begin
            u.mul_en = 1'b1; u.coef_sel = CF_B1; u.src_sel = SRC_W1;
         end
         4'd10: begin
            u.mul_en = 1'b1; u.mul_hi = 1'b1; u.coef_sel = CF_B1; u.src_sel = SRC_W1;
            u.cond = COND_NUM_LT2; u.target = STEP_DRAIN_Y;
         end
         4'd11: begin
            u.mul_en = 1'b1; u.coef_sel = CF_B2; u.src_sel = SRC_W2;
         end
         4'd12: begin
            u.mul_en = 1'b1; u.mul_hi = 1'b1; u.coef_sel = CF_B2; u.src_sel = SRC_W2;
         end
         4'd13: begin
            u = UOP_NOP;
         end
         4'd14: begin
            u.rnd  = RND_Y;
            u.last = 1'b1;
         end
         default: begin
            u = UOP_NOP;
         end
      endcase
      return u;
   endfunction

   logic                  busy_ff;
   logic [STEP_WIDTH-1:0] step_ff;
   logic                  rsp_valid_ff;
   uop_type               uop;
   logic                  stall;
   logic                  exec;
   logic                  accept;
   logic                  take_jump;

   assign uop       = rom_word(step_ff);
   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign stall     = uop.last && rsp_valid_ff && !rsp_ready;
   assign exec      = busy_ff && !stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      case (uop.cond)
         COND_DEN_LT1: take_jump = !ord.den_ge1;
         COND_DEN_LT2: take_jump = !ord.den_ge2;
         COND_NUM_LT1: take_jump = !ord.num_ge1;
         COND_NUM_LT2: take_jump = !ord.num_ge2;
         default:      take_jump = 1'b0;
      endcase
   end

   always_comb begin
      ctl.start = accept && (req_cmd == CMD_FILTER);
      ctl.clear = accept && (req_cmd == CMD_CLEAR);
      ctl.exec  = exec;
      ctl.uop   = uop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec && uop.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && (req_cmd == CMD_FILTER)) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (exec) begin
            if (uop.last) begin
               busy_ff <= 1'b0;
            end else if (take_jump) begin
               step_ff <= uop.target;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   a_start_at_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_FILTER) |=> busy_ff && (step_ff == '0))
      else $error("program did not start at step zero");

   a_clear_no_run: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_CLEAR) |=> !busy_ff)
      else $error("clear command started the program");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= STEP_LAST))
      else $error("step counter ran past the program");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      busy_ff && uop.last && rsp_valid_ff && !rsp_ready |=>
         busy_ff && (step_ff == $past(step_ff)))
      else $error("final step advanced while the result register was full");

endmodule

`default_nettype wire

[hdl/iir_df2_datapath.sv]
`default_nettype none

module iir_df2_datapath import iir_df2_pkg::*; (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ctl_type                        ctl,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                           req_last,
   input  wire logic                           csr_write_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [COEF_WIDTH-1:0]          csr_wdata,
   output ord_type                             ord,
   output rsp_type                             rsp_data
);

   logic signed [COEF_WIDTH-1:0]   b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [ORDER_WIDTH-1:0]         numer_ff, denom_ff;
   logic signed [DELAY_WIDTH-1:0]  w0_ff, w1_ff, w2_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic                           last_ff;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic                           prod_vld_ff, prod_neg_ff, prod_hi_ff;
   logic signed [ACC_WIDTH-1:0]    acc_ff;
   logic                           clip_ff;
   rsp_type                        rsp_ff;

   logic signed [COEF_WIDTH-1:0]   coef_mux;
   logic signed [DELAY_WIDTH-1:0]  src_mux;
   logic signed [CHUNK_WIDTH:0]    chunk;
   logic signed [PROD_WIDTH-1:0]   prod_in;
   logic signed [ACC_WIDTH-1:0]    term;
   logic signed [ACC_WIDTH-1:0]    acc_in;
   logic signed [ACC_WIDTH-1:0]    half;
   logic signed [ACC_WIDTH-1:0]    rnd_sum;
   logic                           fit_w, fit_y;
   logic signed [DELAY_WIDTH-1:0]  w_rnd;
   logic signed [SAMPLE_WIDTH-1:0] y_rnd;
   logic                           cfg_hit;

   always_comb begin
      case (ctl.uop.coef_sel)
         CF_A1:   coef_mux = a1_ff;
         CF_A2:   coef_mux = a2_ff;
         CF_B0:   coef_mux = b0_ff;
         CF_B1:   coef_mux = b1_ff;
         CF_B2:   coef_mux = b2_ff;
         default: coef_mux = b0_ff;
      endcase
      case (ctl.uop.src_sel)
         SRC_W0:  src_mux = w0_ff;
         SRC_W1:  src_mux = w1_ff;
         SRC_W2:  src_mux = w2_ff;
         default: src_mux = w0_ff;
      endcase
   end

   assign chunk = ctl.uop.mul_hi
      ? $signed({src_mux[DELAY_WIDTH-1], src_mux[DELAY_WIDTH-1:CHUNK_WIDTH]})
      : $signed({1'b0, src_mux[CHUNK_WIDTH-1:0]});
   assign prod_in = PROD_WIDTH'(coef_mux) * PROD_WIDTH'(chunk);

   assign term = prod_hi_ff ? (ACC_WIDTH'(prod_ff) <<< CHUNK_WIDTH) : ACC_WIDTH'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.exec) begin
         if (ctl.uop.load_x) begin
            acc_in = ACC_WIDTH'(x_ff) <<< OUT_SHIFT;
         end else if (ctl.uop.rnd == RND_W) begin
            acc_in = '0;
         end else if (prod_vld_ff) begin
            acc_in = prod_neg_ff ? acc_ff - term : acc_ff + term;
         end
      end
   end

   assign half    = (ctl.uop.rnd == RND_W) ? (ACC_WIDTH'(1) <<< (FRAC_BITS - 1))
                                           : (ACC_WIDTH'(1) <<< (OUT_SHIFT - 1));
   assign rnd_sum = acc_ff + half;

   assign fit_w = (&rnd_sum[ACC_WIDTH-1:FRAC_BITS+DELAY_WIDTH-1]) ||
                  !(|rnd_sum[ACC_WIDTH-1:FRAC_BITS+DELAY_WIDTH-1]);
   assign fit_y = (&rnd_sum[ACC_WIDTH-1:OUT_SHIFT+SAMPLE_WIDTH-1]) ||
                  !(|rnd_sum[ACC_WIDTH-1:OUT_SHIFT+SAMPLE_WIDTH-1]);

   assign w_rnd = fit_w ? rnd_sum[FRAC_BITS+DELAY_WIDTH-1:FRAC_BITS]
                : (rnd_sum[ACC_WIDTH-1] ? {1'b1, {(DELAY_WIDTH-1){1'b0}}}
                                        : {1'b0, {(DELAY_WIDTH-1){1'b1}}});
   assign y_rnd = fit_y ? rnd_sum[OUT_SHIFT+SAMPLE_WIDTH-1:OUT_SHIFT]
                : (rnd_sum[ACC_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});

   always_comb begin
      case (reg_index_type'(csr_index))
         REG_FEED_FWD_0, REG_FEED_FWD_1, REG_FEED_FWD_2,
         REG_FEED_BACK_1, REG_FEED_BACK_2,
         REG_NUMER_ORDER, REG_DENOM_ORDER: cfg_hit = csr_write_en;
         default:                          cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff    <= COEF_WIDTH'(1) <<< FRAC_BITS;
         b1_ff    <= '0;
         b2_ff    <= '0;
         a1_ff    <= '0;
         a2_ff    <= '0;
         numer_ff <= '0;
         denom_ff <= '0;
      end else if (csr_write_en) begin
         case (reg_index_type'(csr_index))
            REG_FEED_FWD_0:  b0_ff    <= csr_wdata;
            REG_FEED_FWD_1:  b1_ff    <= csr_wdata;
            REG_FEED_FWD_2:  b2_ff    <= csr_wdata;
            REG_FEED_BACK_1: a1_ff    <= csr_wdata;
            REG_FEED_BACK_2: a2_ff    <= csr_wdata;
            REG_NUMER_ORDER: numer_ff <= csr_wdata[ORDER_WIDTH-1:0];
            REG_DENOM_ORDER: denom_ff <= csr_wdata[ORDER_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_ff       <= '0;
         w2_ff       <= '0;
         prod_vld_ff <= 1'b0;
         clip_ff     <= 1'b0;
      end else begin
         if (cfg_hit || ctl.clear) begin
            w1_ff <= '0;
            w2_ff <= '0;
         end else if (ctl.exec && (ctl.uop.rnd == RND_Y)) begin
            w1_ff <= w0_ff;
            w2_ff <= w1_ff;
         end
         if (ctl.exec) begin
            prod_vld_ff <= ctl.uop.mul_en;
            if (ctl.uop.load_x) begin
               clip_ff <= 1'b0;
            end else if (ctl.uop.rnd == RND_W) begin
               clip_ff <= !fit_w;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x_ff    <= req_sample;
         last_ff <= req_last;
      end
      if (ctl.exec) begin
         prod_ff     <= prod_in;
         prod_neg_ff <= ctl.uop.mul_neg;
         prod_hi_ff  <= ctl.uop.mul_hi;
         if (ctl.uop.rnd == RND_W) begin
            w0_ff <= w_rnd;
         end
         if (ctl.uop.rnd == RND_Y) begin
            rsp_ff.filtered  <= y_rnd;
            rsp_ff.saturated <= clip_ff || !fit_y;
            rsp_ff.last_out  <= last_ff;
         end
      end
      acc_ff <= acc_in;
   end

   always_comb begin
      ord.den_ge1 = (denom_ff != '0);
      ord.den_ge2 = denom_ff[1];
      ord.num_ge1 = (numer_ff != '0);
      ord.num_ge2 = numer_ff[1];
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[hdl/iir_direct_form_two_filter.sv]
// The microcode program of up to 15 steps skips the multiply steps of each denominator tap
// and each numerator tap not in use (an order code of 3 counts as 2); it feeds one shared
// 32 x 25 multiplier, two partial products per tap, and only one item runs at a time, so
// no new request is taken until the result of the last one is written to the output register.
// A clear command gives no result; a result held in the output register
// stalls only the final program step. Synchronous active-high reset clears the delay line.
`default_nettype none

module iir_direct_form_two_filter import iir_df2_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COEF_WIDTH-1:0]      csr_wdata
);

   ctl_type ctl;
   ord_type ord;

   iir_df2_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ord       (ord),
      .ctl       (ctl)
   );

   iir_df2_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .req_sample   (req_data.sample),
      .req_last     (req_data.last_in),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .ord          (ord),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

[dv/iir_direct_form_two_filter_tb.sv]
`timescale 1ns / 100ps

module iir_direct_form_two_filter_tb;
   import iir_df2_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
   localparam logic [COEF_WIDTH-1:0] COEF_MAX  = 32'h7FFF_FFFF;
   localparam logic [COEF_WIDTH-1:0] COEF_MIN  = 32'h8000_0000;
   localparam logic [COEF_WIDTH-1:0] COEF_ONE  = 32'h1000_0000;
   localparam logic [COEF_WIDTH-1:0] COEF_HALF = 32'h0800_0000;
   localparam logic [COEF_WIDTH-1:0] COEF_QTR  = 32'h0400_0000;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int ITEMS_PER_PHASE = 130;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [COEF_WIDTH-1:0] csr_wdata = '0;

   iir_direct_form_two_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow copy of the filter state and coefficients.
   logic signed [COEF_WIDTH-1:0] fwd_coef [3];
   logic signed [COEF_WIDTH-1:0] back_coef [3];
   logic [ORDER_WIDTH-1:0] numer_ord;
   logic [ORDER_WIDTH-1:0] denom_ord;
   logic signed [DELAY_WIDTH-1:0] shadow_line [MAX_ORDER];

   req_type pending_samples [$];
   rsp_type expected_outputs [$];
   int mismatches = 0;

   int burst_left = 1;
   int gap_left = 0;
   int stall_left = 0;
   int stall_rate = 0;
   int hold_left = 0;
   int rx_cycles = 0;
   logic hold_trigger = 1'b0;
   logic hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic clear_shadow_line();
      for (int i = 0; i < MAX_ORDER; i++) begin
         shadow_line[i] = '0;
      end
   endtask

   function automatic int clamp_order(input logic [ORDER_WIDTH-1:0] ord);
      return (ord > MAX_ORDER) ? MAX_ORDER : int'(ord);
   endfunction

   function automatic logic signed [127:0] coef_times_word(
      input logic signed [COEF_WIDTH-1:0] coef,
      input logic signed [DELAY_WIDTH-1:0] word
   );
      logic signed [127:0] cw;
      logic signed [127:0] ww;
      cw = coef;
      ww = word;
      return cw * ww;
   endfunction

   // Rounds half up by the given number of fraction bits, then clips to a signed width.
   function automatic logic signed [127:0] round_to_width(
      input logic signed [127:0] acc,
      input int shift,
      input int width,
      inout logic clip
   );
      logic signed [127:0] r;
      logic signed [127:0] top;
      r = (acc + (128'sd1 <<< (shift - 1))) >>> shift;
      top = 128'sd1 <<< (width - 1);
      if (r >= top) begin
         clip = 1'b1;
         return top - 128'sd1;
      end
      if (r < -top) begin
         clip = 1'b1;
         return -top;
      end
      return r;
   endfunction

   task automatic predict_filter_output(input req_type item);
      logic signed [127:0] acc;
      logic signed [127:0] rounded;
      logic signed [DELAY_WIDTH-1:0] w0;
      logic clip;
      rsp_type r;
      int nd;
      int nn;
      if (item.cmd == CMD_CLEAR) begin
         clear_shadow_line();
         return;
      end
      nd = clamp_order(denom_ord);
      nn = clamp_order(numer_ord);
      clip = 1'b0;
      acc = $signed(item.sample);
      acc = acc <<< OUT_SHIFT;
      for (int i = 1; i <= nd; i++) begin
         acc = acc - coef_times_word(back_coef[i], shadow_line[i-1]);
      end
      rounded = round_to_width(acc, FRAC_BITS, DELAY_WIDTH, clip);
      w0 = rounded[DELAY_WIDTH-1:0];
      acc = coef_times_word(fwd_coef[0], w0);
      for (int i = 1; i <= nn; i++) begin
         acc = acc + coef_times_word(fwd_coef[i], shadow_line[i-1]);
      end
      rounded = round_to_width(acc, OUT_SHIFT, SAMPLE_WIDTH, clip);
      for (int i = MAX_ORDER - 1; i >= 1; i--) begin
         shadow_line[i] = shadow_line[i-1];
      end
      shadow_line[0] = w0;
      r.filtered = rounded[SAMPLE_WIDTH-1:0];
      r.saturated = clip;
      r.last_out = item.last_in;
      expected_outputs.push_back(r);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [COEF_WIDTH-1:0] value);
      logic known;
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      known = 1'b1;
      case (idx)
         REG_FEED_FWD_0: fwd_coef[0] = value;
         REG_FEED_FWD_1: fwd_coef[1] = value;
         REG_FEED_FWD_2: fwd_coef[2] = value;
         REG_FEED_BACK_1: back_coef[1] = value;
         REG_FEED_BACK_2: back_coef[2] = value;
         REG_NUMER_ORDER: numer_ord = value[ORDER_WIDTH-1:0];
         REG_DENOM_ORDER: denom_ord = value[ORDER_WIDTH-1:0];
         default: known = 1'b0;
      endcase
      if (known) begin
         clear_shadow_line();
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_filter(input logic [COEF_WIDTH-1:0] b0, b1, b2, a1, a2,
                              input logic [ORDER_WIDTH-1:0] num, den);
      write_csr(REG_FEED_FWD_0, b0);
      write_csr(REG_FEED_FWD_1, b1);
      write_csr(REG_FEED_FWD_2, b2);
      write_csr(REG_FEED_BACK_1, a1);
      write_csr(REG_FEED_BACK_2, a2);
      write_csr(REG_NUMER_ORDER, ($urandom() << ORDER_WIDTH) | 32'(num));
      write_csr(REG_DENOM_ORDER, ($urandom() << ORDER_WIDTH) | 32'(den));
      @(negedge clock);
   endtask

   task automatic push_item(input logic cmd, input logic [SAMPLE_WIDTH-1:0] sample,
                            input logic last);
      req_type it;
      it.cmd = cmd;
      it.sample = sample;
      it.last_in = last;
      pending_samples.push_back(it);
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_valid || expected_outputs.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [COEF_WIDTH-1:0] pick_coef(input int kind);
      int v;
      if (kind == 1) begin
         return $urandom();
      end
      if (kind == 2) begin
         case ($urandom_range(0, 4))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return COEF_ONE;
            default: return $urandom();
         endcase
      end
      v = int'($urandom_range(0, 1 << 27)) - (1 << 26);
      return 32'(v);
   endfunction

   task automatic push_random_items(input int count);
      logic [SAMPLE_WIDTH-1:0] s;
      int v;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: s = 16'h7FFF;
            1: s = 16'h8000;
            2, 3: begin
               v = int'($urandom_range(0, 511)) - 256;
               s = 16'(v);
            end
            default: s = 16'($urandom());
         endcase
         push_item(($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_FILTER, s,
                   $urandom_range(0, 7) == 0);
      end
   endtask

   // Sender: bursts of transfers separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_filter_output(req_data);
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_samples.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls whose rate changes over time, plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles % 3000 == 0) begin
            stall_rate = $urandom_range(0, 6);
         end
         if (hold_trigger && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stall_rate != 0 && $urandom_range(1, 16) <= stall_rate) begin
            stall_left = $urandom_range(0, 30);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : output_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            $error("output transfer with no sample pending: filtered %0d", rsp_data.filtered);
            mismatches++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_data.filtered !== want.filtered) begin
               $error("filtered: expected %0d, got %0d", want.filtered, rsp_data.filtered);
               mismatches++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0b, got %0b", want.saturated, rsp_data.saturated);
               mismatches++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $error("last_out: expected %0b, got %0b", want.last_out, rsp_data.last_out);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int kind;
      fwd_coef[0] = COEF_ONE;
      fwd_coef[1] = '0;
      fwd_coef[2] = '0;
      back_coef[0] = '0;
      back_coef[1] = '0;
      back_coef[2] = '0;
      numer_ord = '0;
      denom_ord = '0;
      clear_shadow_line();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default coefficients pass the sample straight through.
      push_item(CMD_FILTER, 16'h7FFF, 1'b0);
      push_item(CMD_FILTER, 16'h8000, 1'b1);
      push_item(CMD_FILTER, 16'h0000, 1'b0);
      push_item(CMD_FILTER, 16'h0001, 1'b0);
      push_item(CMD_FILTER, 16'hFFFF, 1'b1);
      push_item(CMD_CLEAR, 16'h1234, 1'b1);
      push_item(CMD_FILTER, 16'h5555, 1'b0);
      push_item(CMD_FILTER, 16'hAAAA, 1'b1);
      wait_idle();

      // Full second order with numerator order code 3; an unknown register write
      // must leave the delay line alone.
      load_filter(COEF_HALF, COEF_HALF, COEF_QTR, -COEF_HALF, COEF_QTR, 2'd3, 2'd2);
      push_item(CMD_FILTER, 16'h7FFF, 1'b0);
      push_item(CMD_FILTER, 16'h8000, 1'b0);
      push_item(CMD_FILTER, 16'd1000, 1'b0);
      wait_idle();
      write_csr(REG_UNUSED, $urandom());
      @(negedge clock);
      push_item(CMD_FILTER, 16'd5000, 1'b0);
      push_item(CMD_FILTER, -16'sd5000, 1'b0);
      push_item(CMD_CLEAR, 16'h0000, 1'b0);
      push_item(CMD_FILTER, 16'd100, 1'b0);
      push_item(CMD_FILTER, 16'h7FFF, 1'b1);
      wait_idle();

      // Strong positive feedback drives the recursion word and the output into clipping.
      load_filter(COEF_MAX, COEF_MIN, '0, COEF_MIN, COEF_MAX, 2'd0, 2'd1);
      for (int i = 0; i < 8; i++) begin
         push_item(CMD_FILTER, 16'h7FFF, i == 7);
      end

      for (int p = 0; p < 10; p++) begin
         wait_idle();
         case (p)
            0: load_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 2'd2, 2'd2);
            1: load_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 2'd3, 2'd3);
            2: load_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           2'd0, 2'd0);
            default: begin
               kind = $urandom_range(0, 3);
               if (kind == 3) begin
                  kind = 0;
               end
               load_filter(pick_coef(kind), pick_coef(kind), pick_coef(kind),
                           pick_coef(kind), pick_coef(kind),
                           2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            end
         endcase
         if (p == 3) begin
            hold_trigger = 1'b1;
         end
         push_random_items(ITEMS_PER_PHASE);
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
